[sv/swbm_pkg.sv]
package swbm_pkg;

	// Host operation codes.
	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_LOAD       = 3'd1,
		OP_START      = 3'd2,
		OP_RESET      = 3'd3,
		OP_DISCONNECT = 3'd4
	} op_t;

	// Master sequencer state.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_TX    = 4'b0010,
		ST_RX    = 4'b0100,
		ST_ERROR = 4'b1000
	} mstate_t;

	// Codes reported on bus_state.
	localparam logic [1:0] BUS_IDLE  = 2'd0;
	localparam logic [1:0] BUS_TX    = 2'd1;
	localparam logic [1:0] BUS_RX    = 2'd2;
	localparam logic [1:0] BUS_ERROR = 2'd3;

	localparam logic [7:0] SYNC_BYTE   = 8'h55;
	localparam logic [7:0] NO_READ_POS = 8'hFF;
	localparam logic [1:0] LAST_PHASE  = 2'd3;

	typedef struct packed {
		logic [2:0] operation;
		logic       line_level;
		logic [3:0] buffer_index;
		logic [7:0] buffer_byte;
		logic [4:0] tx_count;
		logic [7:0] rx_count;
	} cmd_word_t;

	typedef struct packed {
		logic       drive_enable;
		logic       drive_level;
		logic [1:0] bus_state;
		logic       read_valid;
		logic [7:0] read_byte;
	} rsp_word_t;

endpackage

[sv/swbm_chan_if.sv]
interface swbm_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[sv/single_wire_eeprom_bus_master.sv]
// Channel  Dir  Payload      Meaning
// cmd      in   cmd_word_t   one host word: tick, load buffer byte, start, reset, disconnect
// result   out  rsp_word_t   line drive, bus state and an optional received byte
//
// Every command word produces exactly one result word, registered in the cycle after it is taken.
// A word is taken every cycle while the result register is empty or being drained,
// so the sustained rate is one word per clock; only result backpressure stalls it.
// Reset leaves the master in the error state with the line driven low, so the
// first start performs a bus reset. The transmit buffer holds no reset value.
module single_wire_eeprom_bus_master #(
	parameter int BUFFER_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	swbm_chan_if.sink    cmd,
	swbm_chan_if.source  result
);
	import swbm_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);

	// Sequencer state.
	logic [1:0] phase_q;
	logic [3:0] bit_step_q;
	logic [7:0] shift_q;
	logic       cur_bit_q;
	logic [7:0] pos_q;
	logic [7:0] first_rd_q;
	logic [7:0] last_q;
	mstate_t    state_q;
	logic       line_en_q;
	logic       line_out_q;

	// Next-state values for the word at the input.
	logic [1:0] n_phase;
	logic [3:0] n_bit_step;
	logic [7:0] n_shift;
	logic       n_cur_bit;
	logic [7:0] n_pos;
	logic [7:0] n_first_rd;
	logic [7:0] n_last;
	mstate_t    n_state;
	logic       n_line_en;
	logic       n_line_out;
	logic       n_valid;
	logic [7:0] n_byte;
	logic [3:0] bs;
	logic [7:0] pos_inc;

	// Result register.
	logic       rsp_valid_q;
	rsp_word_t  rsp_q;
	logic [1:0] bus_code;

	logic       accept;
	cmd_word_t  c;

	// Buffer access. The byte needed at the end of a byte is the entry at the
	// next position, so the RAM is always addressed one position ahead and a
	// write made in the previous cycle is forwarded around it.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic [7:0]    idx_ext;
	logic [7:0]    pos_d;
	logic [7:0]    fetch_pos;
	logic [AW-1:0] raddr_q;
	logic          fetch_ok_q;
	logic          wr_valid_q;
	logic [AW-1:0] wr_addr_q;
	logic [7:0]    wr_data_q;
	logic [7:0]    fetched;

	assign c          = cmd.payload;
	assign cmd.ready  = !rsp_valid_q || result.ready;
	assign accept     = cmd.valid && cmd.ready;

	assign idx_ext    = {4'b0000, c.buffer_index};
	assign ram_we     = accept && (c.operation == OP_LOAD)
		&& ({1'b0, idx_ext} < 9'(BUFFER_DEPTH));
	assign ram_waddr  = idx_ext[AW-1:0];
	assign pos_d      = accept ? n_pos : pos_q;
	assign fetch_pos  = pos_d + 8'd1;
	assign ram_raddr  = fetch_pos[AW-1:0];

	swbm_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (c.buffer_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
			fetch_ok_q <= 1'b0;
		end else begin
			wr_valid_q <= ram_we;
			fetch_ok_q <= ({1'b0, fetch_pos} < 9'(BUFFER_DEPTH));
		end
	end

	always_ff @(posedge clk) begin
		raddr_q   <= ram_raddr;
		wr_addr_q <= ram_waddr;
		wr_data_q <= c.buffer_byte;
	end

	// Positions past the buffer read as zero.
	always_comb begin
		if (!fetch_ok_q) begin
			fetched = 8'h00;
		end else if (wr_valid_q && (wr_addr_q == raddr_q)) begin
			fetched = wr_data_q;
		end else begin
			fetched = ram_rdata;
		end
	end

	// One quarter-bit tick, or a host operation, per word.
	always_comb begin
		n_phase    = phase_q;
		n_bit_step = bit_step_q;
		n_shift    = shift_q;
		n_cur_bit  = cur_bit_q;
		n_pos      = pos_q;
		n_first_rd = first_rd_q;
		n_last     = last_q;
		n_state    = state_q;
		n_line_en  = line_en_q;
		n_line_out = line_out_q;
		n_valid    = 1'b0;
		n_byte     = 8'h00;
		bs         = bit_step_q + 4'd1;
		pos_inc    = pos_q + 8'd1;

		case (c.operation)
			OP_TICK: begin
				if (state_q == ST_TX || state_q == ST_RX) begin
					// Manchester drive: a 1 is low then high, a 0 is high then low.
					if (state_q == ST_TX) begin
						if (phase_q == 2'd0) begin
							n_line_en  = 1'b1;
							n_line_out = ~cur_bit_q;
						end else if (phase_q == 2'd2) begin
							n_line_out = cur_bit_q;
						end
					end else begin
						// Receive: a bit is 1 when the line is low early and high late.
						if (phase_q == 2'd0) begin
							n_line_en  = 1'b0;
							n_line_out = 1'b1;
						end else if (phase_q == 2'd1) begin
							n_cur_bit = c.line_level;
						end else if (phase_q == LAST_PHASE) begin
							n_cur_bit = c.line_level & ~cur_bit_q;
						end
					end

					n_phase = phase_q + 2'd1;
					if (phase_q == LAST_PHASE) begin
						n_bit_step = bs;
						if (!bs[3]) begin
							// Data bits of the byte.
							if (state_q == ST_TX) begin
								n_cur_bit = shift_q[7];
								n_shift   = {shift_q[6:0], 1'b0};
							end else begin
								n_shift = {shift_q[6:1], shift_q[0] | n_cur_bit, 1'b0};
							end
						end else if (bs == 4'd8) begin
							// Master acknowledge: 1 unless this is the last byte.
							if (state_q == ST_RX) begin
								n_shift = {shift_q[7:1], shift_q[0] | n_cur_bit};
							end
							n_cur_bit = (pos_q != last_q);
							n_state   = ST_TX;
						end else if (bs == 4'd9) begin
							n_state = ST_RX;
						end else if (!n_cur_bit && pos_q != 8'd0) begin
							// Slave acknowledge missing on a byte past the sync byte; the sync byte's is not checked.
							n_state = ST_ERROR;
						end else begin
							n_bit_step = 4'd0;
							if (pos_q >= first_rd_q) begin
								n_valid = 1'b1;
								n_byte  = shift_q;
							end
							n_pos = pos_inc;
							if (pos_inc == 8'd0 || pos_inc > last_q) begin
								n_line_en  = 1'b1;
								n_line_out = 1'b1;
								n_state    = ST_IDLE;
								n_shift    = {shift_q[6:0], 1'b0};
							end else if (pos_inc >= first_rd_q) begin
								n_state = ST_RX;
								n_shift = {shift_q[6:0], 1'b0};
							end else begin
								n_state   = ST_TX;
								n_cur_bit = fetched[7];
								n_shift   = {fetched[6:0], 1'b0};
							end
						end
					end
				end
			end
			OP_LOAD: begin
				// The buffer write itself goes straight to the RAM.
			end
			OP_START: begin
				// Also covers a start from error: the bus reset is folded in.
				n_phase    = 2'd0;
				n_bit_step = 4'd0;
				n_pos      = 8'd0;
				n_last     = {3'b000, c.tx_count} + c.rx_count - 8'd1;
				n_first_rd = (c.rx_count != 8'd0) ? {3'b000, c.tx_count} : NO_READ_POS;
				n_shift    = {SYNC_BYTE[6:0], 1'b0};
				n_cur_bit  = 1'b0;
				n_line_en  = 1'b1;
				n_line_out = 1'b0;
				n_state    = ST_TX;
			end
			OP_RESET: begin
				n_line_en  = 1'b1;
				n_line_out = 1'b1;
				n_state    = ST_IDLE;
			end
			OP_DISCONNECT: begin
				n_line_en  = 1'b1;
				n_line_out = 1'b0;
				n_state    = ST_ERROR;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (n_state)
			ST_IDLE:  bus_code = BUS_IDLE;
			ST_TX:    bus_code = BUS_TX;
			ST_RX:    bus_code = BUS_RX;
			default:  bus_code = BUS_ERROR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 2'd0;
			bit_step_q  <= 4'd0;
			shift_q     <= 8'h00;
			cur_bit_q   <= 1'b0;
			pos_q       <= 8'd0;
			first_rd_q  <= 8'd0;
			last_q      <= 8'd0;
			state_q     <= ST_ERROR;
			line_en_q   <= 1'b1;
			line_out_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q    <= n_phase;
				bit_step_q <= n_bit_step;
				shift_q    <= n_shift;
				cur_bit_q  <= n_cur_bit;
				pos_q      <= n_pos;
				first_rd_q <= n_first_rd;
				last_q     <= n_last;
				state_q    <= n_state;
				line_en_q  <= n_line_en;
				line_out_q <= n_line_out;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (result.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// The result word holds until taken; a new one loads only with an accepted word.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.drive_enable <= n_line_en;
			rsp_q.drive_level  <= n_line_out;
			rsp_q.bus_state    <= bus_code;
			rsp_q.read_valid   <= n_valid;
			rsp_q.read_byte    <= n_byte;
		end
	end

	assign result.valid   = rsp_valid_q;
	assign result.payload = rsp_q;
endmodule

[sv/swbm_ram.sv]
module swbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
